/* hw/rtl/smf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding median filter package
// Shared constants, register map and control structs of the median filter.
// ----------------------------------------------------------------------------
package smf_pkg;

    localparam int MAX_WINDOW_DEF  = 32;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int CFG_LEN_BITS = 6;
    localparam logic [CFG_LEN_BITS-1:0] WIN_LEN_RESET = 6'd3;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic REG_WINDOW_LENGTH = 1'b0;

    typedef struct packed {
        logic start;
        logic clear;
    } smf_req_t;

    typedef struct packed {
        logic done;
    } smf_stat_t;

endpackage

/* hw/rtl/sliding_median_filter_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding median filter unit
// Streaming median filter over signed samples with a programmable window.
// ----------------------------------------------------------------------------
// Samples enter on the s_ stream, one word per sample; s_tlast marks the last
// sample of a signal. Filtered samples leave on the m_ stream, and m_tlast
// flags the last one of the signal. The first D = ceil(N/2) - 1 samples give
// no word; the flagged sample then pushes D zeros, so each signal yields one
// word per sample. The window length N is set through the APB register at
// address 0 and may only be changed while the stream is idle; a write also
// starts a new signal.
// Every pushed value goes through one merge pass over the sorted window, one
// element per cycle, with one equality and one ordering comparator. s_tready
// is low from acceptance until the sample and any flush pushes are done. A
// finished word waits in the output register; the next sample is accepted
// meanwhile, and work stalls only when a new word is ready while the old one
// is still held by the receiver. After reset the window is all zero and N is
// 3.
// ----------------------------------------------------------------------------
module sliding_median_filter_unit import smf_pkg::*; #(
    parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // s_tdata: sample
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,
    input  logic                                s_tvalid,
    input  logic                                s_tlast,
    output logic                                s_tready,
    // m_tdata: median_value
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]    m_tdata,
    output logic                                m_tvalid,
    output logic                                m_tlast,
    input  logic                                m_tready,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [APB_AW-1:0]                   paddr,
    input  logic [APB_DW-1:0]                   pwdata,
    output logic [APB_DW-1:0]                   prdata,
    output logic                                pready
);

    localparam int NW  = $clog2(MAX_WINDOW + 1);
    localparam int TDW = ((SAMPLE_BITS + 7) / 8) * 8;

    typedef enum logic [3:0] {
        T_IDLE = 4'b0001,
        T_PUSH = 4'b0010,
        T_EMIT = 4'b0100,
        T_NEXT = 4'b1000
    } top_state_t;

    top_state_t st_reg;

    logic [CFG_LEN_BITS-1:0] wl_reg;
    logic [CFG_LEN_BITS-1:0] wl_next;
    logic [NW-1:0]           warm_reg;
    logic [NW-1:0]           flush_reg;
    logic                    end_reg;
    logic                    due_reg;
    logic                    out_valid_reg;
    logic                    out_last_reg;
    logic [SAMPLE_BITS-1:0]  out_data_reg;

    logic [NW-1:0]                  win_len;
    logic [NW-1:0]                  lead;
    logic                           cfg_wr;
    logic                           s_acc;
    logic                           out_free;
    logic                           end_clear;
    smf_req_t                       req;
    smf_stat_t                      stat;
    logic signed [SAMPLE_BITS-1:0]  push_value;
    logic signed [SAMPLE_BITS-1:0]  mid_lo;
    logic signed [SAMPLE_BITS-1:0]  mid_hi;
    logic signed [SAMPLE_BITS:0]    pair_sum;
    logic signed [SAMPLE_BITS:0]    pair_adj;
    logic signed [SAMPLE_BITS-1:0]  median;

    always_comb begin
        win_len   = NW'(wl_reg);
        lead      = NW'((({1'b0, win_len} + (NW+1)'(1)) >> 1) - (NW+1)'(1));
        cfg_wr    = psel && penable && pwrite && pready && (paddr[2] == REG_WINDOW_LENGTH);
        s_acc     = s_tvalid && s_tready;
        out_free  = !out_valid_reg || m_tready;
        end_clear = (st_reg == T_NEXT) && (flush_reg == '0) && end_reg;
        req.start = s_acc || ((st_reg == T_NEXT) && (flush_reg != '0));
        req.clear = end_clear || cfg_wr;
        push_value = (st_reg == T_IDLE) ? s_tdata[SAMPLE_BITS-1:0] : '0;

        if (pwdata[CFG_LEN_BITS-1:0] == '0) begin
            wl_next = CFG_LEN_BITS'(1);
        end else if (int'(pwdata[CFG_LEN_BITS-1:0]) > MAX_WINDOW) begin
            wl_next = CFG_LEN_BITS'(MAX_WINDOW);
        end else begin
            wl_next = pwdata[CFG_LEN_BITS-1:0];
        end

        pair_sum = {mid_lo[SAMPLE_BITS-1], mid_lo} + {mid_hi[SAMPLE_BITS-1], mid_hi};
        pair_adj = pair_sum + (pair_sum[SAMPLE_BITS] ? (SAMPLE_BITS+1)'(1) : '0);
        median   = win_len[0] ? mid_hi : pair_adj[SAMPLE_BITS:1];
    end

    smf_window_sort #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_sort (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req        (req),
        .push_value (push_value),
        .win_len    (win_len),
        .stat       (stat),
        .mid_lo     (mid_lo),
        .mid_hi     (mid_hi)
    );

    always_ff @(posedge aclk) begin
        if ((st_reg == T_EMIT) && out_free) begin
            out_data_reg <= median;
            out_last_reg <= end_reg && (flush_reg == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= T_IDLE;
            wl_reg        <= WIN_LEN_RESET;
            warm_reg      <= '0;
            flush_reg     <= '0;
            end_reg       <= 1'b0;
            due_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr) begin
                wl_reg   <= wl_next;
                warm_reg <= '0;
            end
            if ((st_reg == T_EMIT) && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (st_reg)
                T_IDLE: begin
                    if (s_acc) begin
                        due_reg   <= (warm_reg >= lead);
                        end_reg   <= s_tlast;
                        flush_reg <= s_tlast ? lead : '0;
                        st_reg    <= T_PUSH;
                    end
                end
                T_PUSH: begin
                    if (stat.done) begin
                        if (due_reg) begin
                            st_reg <= T_EMIT;
                        end else begin
                            warm_reg <= warm_reg + NW'(1);
                            st_reg   <= T_NEXT;
                        end
                    end
                end
                T_EMIT: begin
                    if (out_free) begin
                        st_reg <= T_NEXT;
                    end
                end
                T_NEXT: begin
                    if (flush_reg != '0) begin
                        due_reg   <= (warm_reg >= lead);
                        flush_reg <= flush_reg - NW'(1);
                        st_reg    <= T_PUSH;
                    end else begin
                        if (end_reg) begin
                            warm_reg <= '0;
                            end_reg  <= 1'b0;
                        end
                        st_reg <= T_IDLE;
                    end
                end
                default: begin
                    st_reg <= T_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (st_reg == T_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDW'(out_data_reg);
    assign m_tlast  = out_last_reg;
    assign prdata   = APB_DW'(wl_reg);
    assign pready   = 1'b1;

endmodule

/* hw/rtl/smf_window_sort.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Median filter window store and sort engine
// Keeps the window in arrival order and in sorted order. One push removes the
// oldest value and inserts the new one through a merge pass over the sorted
// bank, one element per cycle, with one equality and one ordering comparator.
// ----------------------------------------------------------------------------
module smf_window_sort import smf_pkg::*; #(
    parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  smf_req_t                               req,
    input  logic signed [SAMPLE_BITS-1:0]          push_value,
    input  logic [$clog2(MAX_WINDOW+1)-1:0]        win_len,
    output smf_stat_t                              stat,
    output logic signed [SAMPLE_BITS-1:0]          mid_lo,
    output logic signed [SAMPLE_BITS-1:0]          mid_hi
);

    localparam int IW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int NW = $clog2(MAX_WINDOW + 1);

    typedef enum logic [3:0] {
        SS_IDLE = 4'b0001,
        SS_LOAD = 4'b0010,
        SS_STEP = 4'b0100,
        SS_DONE = 4'b1000
    } sort_state_t;

    sort_state_t st_reg;

    logic signed [SAMPLE_BITS-1:0] ring_mem [2**IW];
    logic signed [SAMPLE_BITS-1:0] sort_mem [2**(IW+1)];

    logic signed [SAMPLE_BITS-1:0] ring_q_reg;
    logic signed [SAMPLE_BITS-1:0] sort_q_reg;
    logic signed [SAMPLE_BITS-1:0] old_reg;
    logic signed [SAMPLE_BITS-1:0] new_val_reg;
    logic signed [SAMPLE_BITS-1:0] lo_reg;
    logic signed [SAMPLE_BITS-1:0] hi_reg;

    logic [IW-1:0] slot_reg;
    logic [NW-1:0] fill_reg;
    logic [NW-1:0] r_reg;
    logic [NW-1:0] k_reg;
    logic          old_valid_reg;
    logic          src_zero_reg;
    logic          bank_reg;
    logic          dropped_reg;
    logic          ins_reg;

    logic signed [SAMPLE_BITS-1:0] cur;
    logic signed [SAMPLE_BITS-1:0] sort_wdata;
    logic          at_end;
    logic          take_drop;
    logic          take_ins;
    logic          sort_we;
    logic          ring_we;
    logic [NW-1:0] r_next;
    logic [IW-1:0] rd_idx;
    logic [NW-1:0] lo_idx;
    logic [NW-1:0] hi_idx;
    logic [NW-1:0] last_idx;

    always_comb begin
        last_idx  = win_len - NW'(1);
        hi_idx    = win_len >> 1;
        lo_idx    = hi_idx - NW'(1);
        cur       = src_zero_reg ? '0 : sort_q_reg;
        at_end    = (r_reg >= win_len);
        take_drop = (st_reg == SS_STEP) && !dropped_reg && !at_end && (cur == old_reg);
        take_ins  = (st_reg == SS_STEP) && !take_drop && !ins_reg
                    && (at_end || (new_val_reg <= cur));
        sort_we   = (st_reg == SS_STEP) && !take_drop;
        sort_wdata = take_ins ? new_val_reg : cur;
        r_next    = ((st_reg == SS_STEP) && !take_ins) ? r_reg + NW'(1) : r_reg;
        rd_idx    = (st_reg == SS_STEP) ? r_next[IW-1:0] : '0;
        ring_we   = (st_reg == SS_IDLE) && req.start;
    end

    always_ff @(posedge aclk) begin
        if (ring_we) begin
            ring_mem[slot_reg] <= push_value;
        end
        ring_q_reg <= ring_mem[slot_reg];
    end

    always_ff @(posedge aclk) begin
        if (sort_we) begin
            sort_mem[{~bank_reg, k_reg[IW-1:0]}] <= sort_wdata;
        end
        sort_q_reg <= sort_mem[{bank_reg, rd_idx}];
    end

    always_ff @(posedge aclk) begin
        if (sort_we) begin
            if (k_reg == lo_idx) begin
                lo_reg <= sort_wdata;
            end
            if (k_reg == hi_idx) begin
                hi_reg <= sort_wdata;
            end
        end
        if (ring_we) begin
            new_val_reg <= push_value;
        end
        if (st_reg == SS_LOAD) begin
            old_reg <= old_valid_reg ? ring_q_reg : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= SS_IDLE;
            slot_reg      <= '0;
            fill_reg      <= '0;
            r_reg         <= '0;
            k_reg         <= '0;
            old_valid_reg <= 1'b0;
            src_zero_reg  <= 1'b1;
            bank_reg      <= 1'b0;
            dropped_reg   <= 1'b0;
            ins_reg       <= 1'b0;
        end else begin
            unique case (st_reg)
                SS_IDLE: begin
                    if (req.clear) begin
                        slot_reg     <= '0;
                        fill_reg     <= '0;
                        src_zero_reg <= 1'b1;
                    end else if (req.start) begin
                        old_valid_reg <= (NW'(slot_reg) < fill_reg);
                        fill_reg <= (fill_reg == win_len) ? fill_reg : fill_reg + NW'(1);
                        slot_reg <= (NW'(slot_reg) == last_idx) ? '0 : slot_reg + IW'(1);
                        st_reg   <= SS_LOAD;
                    end
                end
                SS_LOAD: begin
                    r_reg       <= '0;
                    k_reg       <= '0;
                    dropped_reg <= 1'b0;
                    ins_reg     <= 1'b0;
                    st_reg      <= SS_STEP;
                end
                SS_STEP: begin
                    r_reg <= r_next;
                    if (take_drop) begin
                        dropped_reg <= 1'b1;
                    end
                    if (take_ins) begin
                        ins_reg <= 1'b1;
                    end
                    if (sort_we) begin
                        k_reg <= k_reg + NW'(1);
                        if (k_reg == last_idx) begin
                            st_reg <= SS_DONE;
                        end
                    end
                end
                SS_DONE: begin
                    bank_reg     <= ~bank_reg;
                    src_zero_reg <= 1'b0;
                    st_reg       <= SS_IDLE;
                end
                default: begin
                    st_reg <= SS_IDLE;
                end
            endcase
        end
    end

    assign stat.done = (st_reg == SS_DONE);
    assign mid_lo    = lo_reg;
    assign mid_hi    = hi_reg;

endmodule

/* hw/rtl/smf_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding median filter port checker
// Watches the ports of the filter unit for handshake and sequencing errors.
// ----------------------------------------------------------------------------
module smf_checker import smf_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    m_tdata,
    input  logic                                m_tvalid,
    input  logic                                m_tlast,
    input  logic                                m_tready,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [APB_AW-1:0]                   paddr,
    input  logic [APB_DW-1:0]                   prdata
);

    a_out_hold: assert property (@(posedge aclk)
        aresetn && m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("Output word changed while stalled.");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("Block not empty after reset.");

    a_busy_after_accept: assert property (@(posedge aclk)
        aresetn && s_tvalid && s_tready |=> !s_tready)
        else $error("Input accepted again before the push finished.");

    a_len_nonzero: assert property (@(posedge aclk)
        aresetn && psel && penable && pwrite && (paddr[2] == REG_WINDOW_LENGTH)
        |=> prdata[CFG_LEN_BITS-1:0] != '0)
        else $error("Window length written as zero.");

endmodule

bind sliding_median_filter_unit smf_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_smf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tlast  (m_tlast),
    .m_tready (m_tready),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .prdata   (prdata)
);
